// File: hw/rtl/ir_tape_hole_counter_unit_defines.svh
// assertion macros shared by the hole counter rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef IR_TAPE_HOLE_COUNTER_UNIT_DEFINES_SVH
`define IR_TAPE_HOLE_COUNTER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define ITHC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ITHC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ITHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ithc_pkg.sv
// types, constants and lookup tables for the ir tape hole counter
// no dependencies; imported by every rtl module of the block
package ithc_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int COUNT_BITS  = 16;
	localparam int SHOWN_BITS  = 15;
	localparam int SEG_BITS    = 7;
	localparam int PITCH_BITS  = 5;
	localparam int THR_BITS    = 12;
	localparam int CFG_DATA_BITS = 12;
	localparam int CFG_IDX_BITS  = 2;

	// queue between front and back, depth must be a power of two
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// floor(n / p) = (n * ceil(2^23 / p)) >> 23 for n below 2^18, p up to 31
	localparam int RECIP_BITS  = 24;
	localparam int RECIP_SHIFT = 23;
	localparam int PROD_BITS   = 42;

	// decimal split by reciprocal multiply
	localparam logic [15:0] DIV1000_M = 16'd33555;  // shift 25
	localparam logic [10:0] DIV100_M  = 11'd1311;   // shift 17
	localparam logic [7:0]  DIV10_M   = 8'd205;     // shift 11

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_CLEAR  = 1'b1
	} ithc_cmd_t;

	typedef enum logic [1:0] {
		EVT_NONE = 2'd0,
		EVT_UP   = 2'd1,
		EVT_DOWN = 2'd2
	} ithc_step_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MODE  = 2'd0,
		CFG_PITCH = 2'd1,
		CFG_HIGH  = 2'd2,
		CFG_LOW   = 2'd3
	} ithc_cfg_idx_t;

	typedef struct packed {
		logic                  two_sensor_mode;
		logic [PITCH_BITS-1:0] pitch_mm;
		logic [THR_BITS-1:0]   high_threshold;
		logic [THR_BITS-1:0]   low_threshold;
	} ithc_cfg_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic                         clear;
		logic                         changed;
		logic signed [COUNT_BITS-1:0] count;
		ithc_step_t                   step;
	} ithc_item_t;

	// ceil(2^23 / p), pitch zero uses the pitch one entry
	function automatic logic [RECIP_BITS-1:0] pitch_recip(input logic [PITCH_BITS-1:0] p);
		logic [RECIP_BITS-1:0] r;
		unique case (p)
			5'd0:  r = 24'd8388608;
			5'd1:  r = 24'd8388608;
			5'd2:  r = 24'd4194304;
			5'd3:  r = 24'd2796203;
			5'd4:  r = 24'd2097152;
			5'd5:  r = 24'd1677722;
			5'd6:  r = 24'd1398102;
			5'd7:  r = 24'd1198373;
			5'd8:  r = 24'd1048576;
			5'd9:  r = 24'd932068;
			5'd10: r = 24'd838861;
			5'd11: r = 24'd762601;
			5'd12: r = 24'd699051;
			5'd13: r = 24'd645278;
			5'd14: r = 24'd599187;
			5'd15: r = 24'd559241;
			5'd16: r = 24'd524288;
			5'd17: r = 24'd493448;
			5'd18: r = 24'd466034;
			5'd19: r = 24'd441506;
			5'd20: r = 24'd419431;
			5'd21: r = 24'd399458;
			5'd22: r = 24'd381301;
			5'd23: r = 24'd364723;
			5'd24: r = 24'd349526;
			5'd25: r = 24'd335545;
			5'd26: r = 24'd322639;
			5'd27: r = 24'd310690;
			5'd28: r = 24'd299594;
			5'd29: r = 24'd289263;
			5'd30: r = 24'd279621;
			5'd31: r = 24'd270601;
		endcase
		return r;
	endfunction

	function automatic logic [SEG_BITS-1:0] seg_pattern(input logic [3:0] digit);
		logic [SEG_BITS-1:0] pat;
		case (digit)
			4'd0: pat = 7'h77;
			4'd1: pat = 7'h24;
			4'd2: pat = 7'h5D;
			4'd3: pat = 7'h5B;
			4'd4: pat = 7'h3A;
			4'd5: pat = 7'h6B;
			4'd6: pat = 7'h6F;
			4'd7: pat = 7'h52;
			4'd8: pat = 7'h7F;
			4'd9: pat = 7'h7A;
			default: pat = '0;
		endcase
		return pat;
	endfunction

endpackage

// File: hw/rtl/ithc_front.sv
// front end: hysteresis latches, step detection and the saturating hole counter
// depends on ithc_pkg; writes one classified word per accepted input
module ithc_front
	import ithc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  ithc_cfg_t              cfg,
	input  logic                   push,
	output logic                   full,
	input  logic                   cmd,
	input  logic [SAMPLE_BITS-1:0] sample_a,
	input  logic [SAMPLE_BITS-1:0] sample_b,
	input  logic                   fifo_full,
	output logic                   wr_en,
	output ithc_item_t             wr_item
);

	logic                         level_a_q;
	logic                         level_b_q;
	logic [1:0]                   prev_pair_q;
	logic                         single_level_q;
	logic                         single_prev_q;
	logic signed [COUNT_BITS-1:0] count_q;

	logic                         la_n;
	logic                         lb_n;
	logic                         sl_n;
	logic [1:0]                   pair_n;
	ithc_step_t                   step;
	logic                         changed;
	logic                         clear;
	logic signed [COUNT_BITS-1:0] count_n;
	logic                         accept;

	function automatic logic hyst(input logic level, input logic [SAMPLE_BITS-1:0] smp,
		input logic [THR_BITS-1:0] hi, input logic [THR_BITS-1:0] lo);
		logic res;
		// high test wins when thresholds cross
		if (smp > hi) res = 1'b1;
		else if (smp < lo) res = 1'b0;
		else res = level;
		return res;
	endfunction

	assign accept = push && !fifo_full;
	assign full   = fifo_full;
	assign clear  = (ithc_cmd_t'(cmd) == CMD_CLEAR);

	always_comb begin
		la_n   = hyst(level_a_q, sample_a, cfg.high_threshold, cfg.low_threshold);
		lb_n   = hyst(level_b_q, sample_b, cfg.high_threshold, cfg.low_threshold);
		sl_n   = hyst(single_level_q, sample_a, cfg.high_threshold, cfg.low_threshold);
		pair_n = {lb_n, la_n};
		step   = EVT_NONE;
		if (!clear) begin
			if (cfg.two_sensor_mode) begin
				// leaving 11 gives the direction
				if (prev_pair_q == 2'b11) begin
					if (pair_n == 2'b01) step = EVT_UP;
					else if (pair_n == 2'b10) step = EVT_DOWN;
				end
			end else if (sl_n && !single_prev_q) begin
				step = EVT_UP;
			end
		end
		changed = ((step == EVT_UP) && (count_q != {1'b0, {(COUNT_BITS-1){1'b1}}})) ||
			((step == EVT_DOWN) && (count_q != {1'b1, {(COUNT_BITS-1){1'b0}}}));
		count_n = (step == EVT_UP) ? count_q + 16'sd1 : count_q - 16'sd1;

		wr_item.clear   = clear;
		wr_item.changed = changed;
		wr_item.step    = step;
		if (clear) wr_item.count = '0;
		else if (changed) wr_item.count = count_n;
		else wr_item.count = count_q;
	end

	assign wr_en = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_a_q      <= 1'b1;
			level_b_q      <= 1'b1;
			prev_pair_q    <= 2'b00;
			single_level_q <= 1'b0;
			single_prev_q  <= 1'b1;
			count_q        <= '0;
		end else if (accept) begin
			count_q <= wr_item.count;
			if (!clear) begin
				if (cfg.two_sensor_mode) begin
					level_a_q   <= la_n;
					level_b_q   <= lb_n;
					prev_pair_q <= pair_n;
				end else begin
					single_level_q <= sl_n;
					single_prev_q  <= sl_n;
				end
			end
		end
	end

endmodule

// File: hw/rtl/ithc_fifo.sv
// short word queue between the front end and the back end
// depends on ithc_pkg and the assertion macro header
`include "ir_tape_hole_counter_unit_defines.svh"

module ithc_fifo
	import ithc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  ithc_item_t wr_item,
	input  logic       rd_en,
	output ithc_item_t rd_item,
	output logic       full,
	output logic       empty
);

	localparam int CNT_W = FIFO_AW + 1;

	ithc_item_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	`ITHC_ASSERT_ALWAYS(a_fifo_bound, cnt_q <= CNT_W'(FIFO_DEPTH), "fifo count above depth")
	`ITHC_ASSERT_ALWAYS(a_fifo_ptrs, (wr_ptr_q - rd_ptr_q) == cnt_q[FIFO_AW-1:0], "fifo pointers disagree with count")
	`ITHC_ASSERT_NEXT(a_fifo_grow, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1, "fifo count missed a write")

endmodule

// File: hw/rtl/ithc_back.sv
// back end: shown value by reciprocal multiply, decimal split, segment patterns
// depends on ithc_pkg and the assertion macro header; owns the result register
`include "ir_tape_hole_counter_unit_defines.svh"

module ithc_back
	import ithc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [PITCH_BITS-1:0]        pitch_mm,
	input  ithc_item_t                   rd_item,
	input  logic                         fifo_empty,
	output logic                         rd_en,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COUNT_BITS-1:0] hole_count,
	output logic [SHOWN_BITS-1:0]        shown_value,
	output logic [1:0]                   step_event,
	output logic [SEG_BITS-1:0]          seg_hundreds,
	output logic [SEG_BITS-1:0]          seg_tens,
	output logic [SEG_BITS-1:0]          seg_ones
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SAT,
		ST_MOD,
		ST_REM,
		ST_HUN,
		ST_LOW,
		ST_TEN,
		ST_DONE
	} state_t;

	state_t                       state_q;
	ithc_item_t                   item_q;
	logic [SHOWN_BITS-1:0]        shown_q;
	logic [PROD_BITS-1:0]         prod_q;
	logic [9:0]                   rem_q;
	logic [3:0]                   hund_q;
	logic [6:0]                   low_q;
	logic                         out_valid_q;
	logic signed [COUNT_BITS-1:0] hole_count_q;
	logic [SHOWN_BITS-1:0]        shown_value_q;
	logic [1:0]                   step_event_q;
	logic [SEG_BITS-1:0]          seg_hundreds_q;
	logic [SEG_BITS-1:0]          seg_tens_q;
	logic [SEG_BITS-1:0]          seg_ones_q;

	logic [COUNT_BITS-1:0]        mag;
	logic [17:0]                  mag4;
	logic [15:0]                  rem_full;
	logic [9:0]                   low_full;
	logic [6:0]                   ones_full;
	logic [3:0]                   tens;
	logic                         slot_free;

	always_comb begin
		mag       = item_q.count[COUNT_BITS-1] ? COUNT_BITS'(-item_q.count)
			: COUNT_BITS'(item_q.count);
		mag4      = {mag, 2'b00};
		// shown mod 1000 from the registered quotient
		rem_full  = {1'b0, shown_q} - 16'(prod_q[30:25]) * 16'd1000;
		low_full  = rem_q - 10'(prod_q[20:17]) * 10'd100;
		tens      = prod_q[14:11];
		ones_full = low_q - 7'(tens) * 7'd10;
	end

	assign slot_free = !out_valid_q || pop;
	assign rd_en     = (state_q == ST_IDLE) && !fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			item_q         <= '0;
			shown_q        <= '0;
			prod_q         <= '0;
			rem_q          <= '0;
			hund_q         <= '0;
			low_q          <= '0;
			out_valid_q    <= 1'b0;
			hole_count_q   <= '0;
			shown_value_q  <= '0;
			step_event_q   <= '0;
			seg_hundreds_q <= '0;
			seg_tens_q     <= '0;
			seg_ones_q     <= '0;
		end else begin
			// the done state reloads the output register itself
			if (out_valid_q && pop && (state_q != ST_DONE)) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!fifo_empty) begin
						item_q <= rd_item;
						if (rd_item.clear) shown_q <= '0;
						state_q <= rd_item.changed ? ST_DIV : ST_MOD;
					end
				end
				ST_DIV: begin
					prod_q  <= {24'b0, mag4} * {18'b0, pitch_recip(pitch_mm)};
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					// quotient above 15 bits saturates
					shown_q <= (|prod_q[PROD_BITS-1:RECIP_SHIFT+SHOWN_BITS]) ? '1
						: prod_q[RECIP_SHIFT+SHOWN_BITS-1:RECIP_SHIFT];
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					prod_q  <= PROD_BITS'(shown_q) * PROD_BITS'(DIV1000_M);
					state_q <= ST_REM;
				end
				ST_REM: begin
					rem_q   <= rem_full[9:0];
					state_q <= ST_HUN;
				end
				ST_HUN: begin
					prod_q  <= PROD_BITS'(rem_q) * PROD_BITS'(DIV100_M);
					state_q <= ST_LOW;
				end
				ST_LOW: begin
					hund_q  <= prod_q[20:17];
					low_q   <= low_full[6:0];
					state_q <= ST_TEN;
				end
				ST_TEN: begin
					prod_q  <= PROD_BITS'(low_q) * PROD_BITS'(DIV10_M);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						out_valid_q    <= 1'b1;
						hole_count_q   <= item_q.count;
						shown_value_q  <= shown_q;
						step_event_q   <= item_q.step;
						seg_hundreds_q <= seg_pattern(hund_q);
						seg_tens_q     <= seg_pattern(tens);
						seg_ones_q     <= seg_pattern(ones_full[3:0]);
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty        = !out_valid_q;
	assign hole_count   = hole_count_q;
	assign shown_value  = shown_value_q;
	assign step_event   = step_event_q;
	assign seg_hundreds = seg_hundreds_q;
	assign seg_tens     = seg_tens_q;
	assign seg_ones     = seg_ones_q;

	`ITHC_ASSERT_IMPLY(a_back_rem, state_q == ST_HUN, rem_q < 10'd1000, "mod 1000 out of range")
	`ITHC_ASSERT_IMPLY(a_back_low, state_q == ST_TEN, low_q < 7'd100, "mod 100 out of range")
	`ITHC_ASSERT_IMPLY(a_back_digits, state_q == ST_DONE, (tens < 4'd10) && (hund_q < 4'd10), "bad digit")

endmodule

// File: hw/rtl/ir_tape_hole_counter_unit.sv
// top level of the ir tape hole counter: configuration registers and block wiring
// depends on ithc_pkg, ithc_front, ithc_fifo and ithc_back
//
// Counts tape holes from pairs of 12-bit IR sensor samples with hysteresis, in
// one-sensor rising-edge mode or two-sensor direction mode, and returns one
// result word per input word: signed count, shown parts count
// floor(|count|*4/pitch) saturated at 32767, step event and three seven-segment
// patterns of the shown value mod 1000. The front end classifies and counts one
// word per cycle into a four-word queue while the queue is not full; the back
// end sequencer then does reciprocal multiply, saturation and decimal split on
// a word whose count changed and only the decimal split on any other word, and
// reads no new word before it is done with the last. A finished word waits in
// an output register while the next one is worked on. Configuration writes are
// always ready and take effect on the next cycle; write them only while idle.
module ir_tape_hole_counter_unit
	import ithc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         cmd,
	input  logic [SAMPLE_BITS-1:0]       sample_a,
	input  logic [SAMPLE_BITS-1:0]       sample_b,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COUNT_BITS-1:0] hole_count,
	output logic [SHOWN_BITS-1:0]        shown_value,
	output logic [1:0]                   step_event,
	output logic [SEG_BITS-1:0]          seg_hundreds,
	output logic [SEG_BITS-1:0]          seg_tens,
	output logic [SEG_BITS-1:0]          seg_ones,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

	ithc_cfg_t  cfg_q;
	logic       fifo_full;
	logic       fifo_empty;
	logic       wr_en;
	logic       rd_en;
	ithc_item_t wr_item;
	ithc_item_t rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_sensor_mode <= 1'b0;
			cfg_q.pitch_mm        <= 5'd4;
			cfg_q.high_threshold  <= 12'd450;
			cfg_q.low_threshold   <= 12'd300;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ithc_cfg_idx_t'(cfg_index))
				CFG_MODE:  cfg_q.two_sensor_mode <= cfg_data[0];
				CFG_PITCH: cfg_q.pitch_mm        <= cfg_data[PITCH_BITS-1:0];
				CFG_HIGH:  cfg_q.high_threshold  <= cfg_data[THR_BITS-1:0];
				CFG_LOW:   cfg_q.low_threshold   <= cfg_data[THR_BITS-1:0];
			endcase
		end
	end

	ithc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.sample_a  (sample_a),
		.sample_b  (sample_b),
		.fifo_full (fifo_full),
		.wr_en     (wr_en),
		.wr_item   (wr_item)
	);

	ithc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_item (wr_item),
		.rd_en   (rd_en),
		.rd_item (rd_item),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	ithc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pitch_mm     (cfg_q.pitch_mm),
		.rd_item      (rd_item),
		.fifo_empty   (fifo_empty),
		.rd_en        (rd_en),
		.empty        (empty),
		.pop          (pop),
		.hole_count   (hole_count),
		.shown_value  (shown_value),
		.step_event   (step_event),
		.seg_hundreds (seg_hundreds),
		.seg_tens     (seg_tens),
		.seg_ones     (seg_ones)
	);

endmodule
